### hdl/uare_pkg.sv
// shared types and constants of the usb audio rate estimator
package uare_pkg;

   localparam int WINDOW_BUCKETS     = 64;
   localparam int BUCKETS_PER_SECOND = 4;
   localparam int SLOT_W             = $clog2(WINDOW_BUCKETS);
   localparam int ADDR_W             = SLOT_W + 1;
   localparam int NSEED              = (BUCKETS_PER_SECOND < WINDOW_BUCKETS) ?
                                       BUCKETS_PER_SECOND : WINDOW_BUCKETS;
   localparam logic [31:0] TICKS_PER_BUCKET = 32'(100000000 / BUCKETS_PER_SECOND);
   localparam logic [31:0] NOMINAL_RATIO    = 32'h8000_0000;
   localparam logic [3:0]  IDLE_LIMIT       = 4'd8;
   localparam logic [13:0] BYTE_SCALE       = 14'd12500;
   localparam int          SCALE_SHIFT      = 19;
   localparam int          RATIO_SHIFT      = 12;

   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_SOF     = 2'd1,
      OP_RESTART = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      REG_OUT_BPM = 1'b0,
      REG_IN_BPM  = 1'b1
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_CALC, ST_DIV1, ST_DIV1W, ST_DIV2, ST_DIV2W,
      ST_SEED, ST_SEED_W, ST_OUT
   } state_type;

   // bucket memory write request
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       bytes;
      logic [31:0]       ticks;
   } mem_wr_type;

endpackage

### hdl/uare_bucket_ram.sv
// bucket memory: byte count and tick span per slot, both directions
module uare_bucket_ram
   import uare_pkg::*;
(
   input  logic              clock,
   input  mem_wr_type        wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_bytes,
   output logic [31:0]       rd_ticks
);

   logic [63:0] mem [2*WINDOW_BUCKETS];
   logic [63:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= {wr.bytes, wr.ticks};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_bytes = rd_ff[63:32];
   assign rd_ticks = rd_ff[31:0];

endmodule

### hdl/uare_divider.sv
// serial restoring divider, 64-bit dividend over 64-bit divisor, one bit a cycle
module uare_divider
   import uare_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [63:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        zero_ff, zero_in;
   logic [64:0] shifted;
   logic [65:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      shifted = {rem_ff[63:0], quo_ff[63]};
      diff    = {1'b0, shifted} - {2'b0, den_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         zero_in = (divisor == 64'd0);
      end else if (busy_ff) begin
         if (diff[65]) begin
            rem_in = shifted;
            quo_in = {quo_ff[62:0], 1'b0};
         end else begin
            rem_in = diff[64:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      zero_ff <= zero_in;
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? 32'hFFFF_FFFF : quo_ff[31:0];

endmodule

### hdl/usb_audio_rate_estimator.sv
// top level of the usb audio rate estimator
// a rate sample passes a bucket read, a multiply and two 64-step serial divisions in the shared
// divider before its result word is formed; a restarting sample first sweeps all WINDOW_BUCKETS
// slots of its direction (seeding sweep), a held sample goes straight from the bucket read to its
// word; tick and restart words give no result word; one sample is worked on at a time
// reset (synchronous) restores the registers and marks both directions for restart;
// the bucket memory is not cleared, a restart sweep writes it before any read
module usb_audio_rate_estimator
   import uare_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_timestamp,
   input  logic [15:0] req_data_length,
   input  logic        req_direction,
   input  logic        req_update,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_rate_ratio,
   output logic        rsp_held,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   state_type   state_ff, state_in;
   logic [15:0] out_bpm_ff, in_bpm_ff;
   logic [31:0] ts_ff;
   logic [15:0] len_ff;
   logic        dir_ff, upd_ff;
   logic [31:0] wsum_b_ff [2];
   logic [31:0] wsum_t_ff [2];
   logic [31:0] open_b_ff [2];
   logic [31:0] open_s_ff [2];
   logic [SLOT_W-1:0] slot_ff [2];
   logic [1:0]  restart_ff;
   logic [31:0] last_ff [2];
   logic        data_ff, hold_ff;
   logic [3:0]  idle_ff;
   logic [31:0] span_ff, btot_ff, ttot_ff, open_new_ff;
   logic [45:0] prod_ff;
   logic [31:0] ratio_ff;
   logic        held_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_ratio_ff;
   logic        rsp_held_ff;
   logic [SLOT_W:0] seed_cnt_ff;
   logic [31:0] seed_ff;

   logic        req_fire, cfg_wr, div_start, div_done;
   logic [63:0] div_num, div_den;
   logic [31:0] div_q;
   logic [31:0] rd_bytes, rd_ticks;
   logic [ADDR_W-1:0] rd_addr;
   mem_wr_type  wr;
   logic [15:0] bpm;
   logic [31:0] open_add;

   assign req_fire = req_valid && req_ready;
   assign cfg_wr   = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign prdata   = (paddr[2] == REG_IN_BPM) ? {16'd0, in_bpm_ff} : {16'd0, out_bpm_ff};
   assign bpm      = dir_ff ? in_bpm_ff : out_bpm_ff;
   assign open_add = open_b_ff[dir_ff] + (upd_ff ? {16'd0, len_ff} : 32'd0);

   uare_bucket_ram u_ram (
      .clock(clock), .wr(wr), .rd_addr(rd_addr),
      .rd_bytes(rd_bytes), .rd_ticks(rd_ticks)
   );

   uare_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_num), .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   assign rd_addr = {dir_ff, slot_ff[dir_ff]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_operation == OP_SAMPLE) state_in = ST_READ;
         end
         ST_READ: begin
            if (hold_ff) state_in = ST_OUT;
            else if (restart_ff[dir_ff]) state_in = ST_SEED;
            else state_in = ST_CALC;
         end
         ST_CALC:  state_in = ST_DIV1;
         ST_DIV1:  state_in = ST_DIV1W;
         ST_DIV1W: if (div_done) state_in = ST_DIV2;
         ST_DIV2:  state_in = ST_DIV2W;
         ST_DIV2W: if (div_done) state_in = ST_OUT;
         ST_SEED:  if (seed_cnt_ff == (SLOT_W+1)'(WINDOW_BUCKETS - 1)) state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      div_start = (state_ff == ST_DIV1) || (state_ff == ST_DIV2);
      if (state_ff == ST_DIV1) begin
         div_num = 64'({prod_ff, {SCALE_SHIFT{1'b0}}});
         div_den = {35'd0, ttot_ff[31:3]};
      end else begin
         div_num = {20'd0, div_q, {RATIO_SHIFT{1'b0}}};
         div_den = {48'd0, bpm};
      end
      wr.en    = 1'b0;
      wr.addr  = rd_addr;
      wr.bytes = open_new_ff;
      wr.ticks = span_ff;
      if (state_ff == ST_SEED) begin
         wr.en    = 1'b1;
         wr.addr  = {dir_ff, seed_cnt_ff[SLOT_W-1:0]};
         if (seed_cnt_ff >= (SLOT_W+1)'(WINDOW_BUCKETS - NSEED)) begin
            wr.bytes = seed_ff;
            wr.ticks = TICKS_PER_BUCKET;
         end else begin
            wr.bytes = '0;
            wr.ticks = '0;
         end
      end else if (state_ff == ST_CALC) begin
         wr.en = upd_ff && (span_ff >= TICKS_PER_BUCKET);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_bpm_ff   <= 16'd128;
         in_bpm_ff    <= 16'd192;
         restart_ff   <= 2'b11;
         data_ff      <= 1'b0;
         hold_ff      <= 1'b0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < 2; d++) begin
            wsum_b_ff[d] <= '0;
            wsum_t_ff[d] <= '0;
            open_b_ff[d] <= '0;
            open_s_ff[d] <= '0;
            slot_ff[d]   <= '0;
            last_ff[d]   <= NOMINAL_RATIO;
         end
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            if (paddr[2] == REG_OUT_BPM && paddr[1:0] == 2'd0) out_bpm_ff <= pwdata[15:0];
            if (paddr[2] == REG_IN_BPM && paddr[1:0] == 2'd0)  in_bpm_ff  <= pwdata[15:0];
         end
         // result word register, loaded only when the previous word is gone
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
            rsp_ratio_ff <= ratio_ff;
            rsp_held_ff  <= held_ff;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            ts_ff  <= req_timestamp;
            len_ff <= req_data_length;
            dir_ff <= req_direction;
            upd_ff <= req_update;
            case (req_operation)
               OP_SOF: begin
                  if (data_ff) begin
                     idle_ff <= '0;
                     data_ff <= 1'b0;
                  end else begin
                     if (idle_ff < IDLE_LIMIT + 4'd1) idle_ff <= idle_ff + 4'd1;
                     if (idle_ff >= IDLE_LIMIT) hold_ff <= 1'b1;
                  end
               end
               OP_RESTART: restart_ff <= 2'b11;
               OP_SAMPLE:  data_ff <= 1'b1;
               default: ;
            endcase
         end
         case (state_ff)
            ST_READ: begin
               span_ff     <= ts_ff - open_s_ff[dir_ff];
               open_new_ff <= open_add;
               btot_ff     <= open_add + wsum_b_ff[dir_ff];
               ttot_ff     <= ts_ff - open_s_ff[dir_ff] + wsum_t_ff[dir_ff];
               seed_ff     <= 32'((bpm * 26'd1000) / BUCKETS_PER_SECOND);
               seed_cnt_ff <= '0;
               if (hold_ff) begin
                  hold_ff          <= 1'b0;
                  open_s_ff[dir_ff] <= ts_ff;
                  open_b_ff[dir_ff] <= '0;
                  ratio_ff         <= last_ff[dir_ff];
                  held_ff          <= 1'b1;
               end else if (restart_ff[dir_ff]) begin
                  restart_ff[dir_ff] <= 1'b0;
                  wsum_b_ff[dir_ff]  <= '0;
                  wsum_t_ff[dir_ff]  <= '0;
                  open_b_ff[dir_ff]  <= '0;
                  open_s_ff[dir_ff]  <= ts_ff;
                  slot_ff[dir_ff]    <= '0;
                  ratio_ff           <= NOMINAL_RATIO;
                  held_ff            <= 1'b0;
               end else begin
                  open_b_ff[dir_ff] <= open_add;
               end
            end
            ST_SEED: begin
               seed_cnt_ff <= seed_cnt_ff + 1'b1;
               wsum_b_ff[dir_ff] <= wsum_b_ff[dir_ff] + wr.bytes;
               wsum_t_ff[dir_ff] <= wsum_t_ff[dir_ff] + wr.ticks;
            end
            ST_CALC: begin
               prod_ff <= btot_ff * BYTE_SCALE;
               // close the bucket, replacing the oldest slot read last cycle
               if (wr.en) begin
                  wsum_b_ff[dir_ff] <= wsum_b_ff[dir_ff] + open_new_ff - rd_bytes;
                  wsum_t_ff[dir_ff] <= wsum_t_ff[dir_ff] + span_ff - rd_ticks;
                  open_b_ff[dir_ff] <= '0;
                  open_s_ff[dir_ff] <= ts_ff;
                  slot_ff[dir_ff]   <= slot_ff[dir_ff] + 1'b1;
               end
            end
            ST_DIV2W: begin
               if (div_done) begin
                  ratio_ff        <= div_q;
                  held_ff         <= 1'b0;
                  last_ff[dir_ff] <= div_q;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rate_ratio = rsp_ratio_ff;
   assign rsp_held       = rsp_held_ff;

endmodule

### hdl/uare_checker.sv
// port-level checker for the rate estimator, bound to the top level
module uare_checker
   import uare_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_rate_ratio,
   input logic        rsp_held,
   input logic        pready
);

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_rate_ratio) && $stable(rsp_held))
      else $error("result changed while stalled");

   a_no_rsp_after_sof: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation != OP_SAMPLE && !rsp_valid |=> !rsp_valid)
      else $error("result without a sample");

   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_SAMPLE |=> !req_ready)
      else $error("sample did not occupy the block");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

endmodule

bind usb_audio_rate_estimator uare_checker u_uare_checker (.*);

### verif/tb_usb_audio_rate_estimator.sv
// testbench of the usb audio rate estimator: directed and random words checked against a behavioral predictor
`timescale 1ns / 100ps

module tb_usb_audio_rate_estimator;
   import uare_pkg::*;

   localparam int LIMIT_CYCLES = 2000000;

   typedef struct packed {
      op_type      op;
      logic [31:0] ts;
      logic [15:0] len;
      logic        dir;
      logic        upd;
   } word_type;

   typedef struct packed {
      logic [31:0] ratio;
      logic        held;
   } rate_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic [31:0] req_timestamp = '0;
   logic [15:0] req_data_length = '0;
   logic        req_direction = 1'b0;
   logic        req_update = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_rate_ratio;
   logic        rsp_held;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   usb_audio_rate_estimator dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [31:0] bpm [2];
   logic [31:0] bkt_bytes [2][WINDOW_BUCKETS];
   logic [31:0] bkt_ticks [2][WINDOW_BUCKETS];
   logic [31:0] win_bytes [2], win_ticks [2], open_bytes [2], open_start [2];
   logic [5:0]  slot [2];
   logic        restart_due [2];
   logic [31:0] prev_ratio [2];
   logic        seen_data, hold_armed;
   logic [3:0]  idle_cnt;

   word_type pending_words [$];
   rate_type expected_rates [$];
   int       errors = 0;
   int       accepted = 0;
   int       total_words = 0;
   bit       calm = 1'b0;
   bit       hold_off = 1'b0;
   longint   cycles = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   function automatic logic [31:0] sat_div(input logic [63:0] num, input logic [63:0] den);
      if (den == 0) return 32'hFFFF_FFFF;
      return 32'(num / den);
   endfunction

   task automatic predictor_reset();
      bpm[0] = 128;
      bpm[1] = 192;
      for (int d = 0; d < 2; d++) begin
         win_bytes[d] = 0; win_ticks[d] = 0; open_bytes[d] = 0; open_start[d] = 0;
         slot[d] = 0; restart_due[d] = 1; prev_ratio[d] = NOMINAL_RATIO;
      end
      seen_data = 0; hold_armed = 0; idle_cnt = 0;
   endtask

   task automatic predict_rate(input word_type w);
      logic [31:0] seed, span, btot, ttot, per_s, ratio;
      logic [63:0] scaled;
      int d;
      d = w.dir;
      case (w.op)
         OP_SOF: begin
            if (seen_data) begin
               idle_cnt = 0; seen_data = 0;
            end else begin
               if (idle_cnt < IDLE_LIMIT + 1) idle_cnt++;
               if (idle_cnt > IDLE_LIMIT) hold_armed = 1;
            end
         end
         OP_RESTART: begin
            restart_due[0] = 1; restart_due[1] = 1;
         end
         OP_SAMPLE: begin
            seen_data = 1;
            if (hold_armed) begin
               hold_armed = 0;
               open_start[d] = w.ts; open_bytes[d] = 0;
               expected_rates.push_back('{prev_ratio[d], 1'b1});
            end else if (restart_due[d]) begin
               restart_due[d] = 0;
               seed = 32'((64'(bpm[d]) * 1000) / BUCKETS_PER_SECOND);
               win_bytes[d] = 0; win_ticks[d] = 0;
               for (int i = 0; i < WINDOW_BUCKETS; i++) begin
                  bkt_bytes[d][i] = (i >= WINDOW_BUCKETS - NSEED) ? seed : 0;
                  bkt_ticks[d][i] = (i >= WINDOW_BUCKETS - NSEED) ? TICKS_PER_BUCKET : 0;
                  win_bytes[d] += bkt_bytes[d][i];
                  win_ticks[d] += bkt_ticks[d][i];
               end
               open_bytes[d] = 0; open_start[d] = w.ts; slot[d] = 0;
               expected_rates.push_back('{NOMINAL_RATIO, 1'b0});
            end else begin
               if (w.upd) open_bytes[d] += w.len;
               span = w.ts - open_start[d];
               btot = open_bytes[d] + win_bytes[d];
               ttot = span + win_ticks[d];
               scaled = (64'(btot) * BYTE_SCALE) << SCALE_SHIFT;
               per_s = sat_div(scaled, 64'(ttot >> 3));
               ratio = sat_div(64'(per_s) << RATIO_SHIFT, 64'(bpm[d]));
               if (w.upd && span >= TICKS_PER_BUCKET) begin
                  win_bytes[d] += open_bytes[d] - bkt_bytes[d][slot[d]];
                  win_ticks[d] += span - bkt_ticks[d][slot[d]];
                  bkt_bytes[d][slot[d]] = open_bytes[d];
                  bkt_ticks[d][slot[d]] = span;
                  open_bytes[d] = 0; open_start[d] = w.ts;
                  slot[d] = slot[d] + 1;
               end
               prev_ratio[d] = ratio;
               expected_rates.push_back('{ratio, 1'b0});
            end
         end
         default: ;
      endcase
   endtask

   // driver
   int gap = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_rate(pending_words.pop_front());
            accepted <= accepted + 1;
         end
         if (req_valid && !req_ready) begin
            // hold the word
         end else if (gap > 0) begin
            gap <= gap - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() > (req_valid && req_ready ? 0 : 0) &&
                      pending_words.size() != 0) begin
            req_valid <= 1'b1;
            req_operation <= pending_words[0].op;
            req_timestamp <= pending_words[0].ts;
            req_data_length <= pending_words[0].len;
            req_direction <= pending_words[0].dir;
            req_update <= pending_words[0].upd;
            if (!calm && $urandom_range(0, 9) == 0) gap <= $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and receiver idling
   int stall = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rates.size() == 0) begin
               report("unexpected word", rsp_rate_ratio, 0);
            end else begin
               rate_type e;
               e = expected_rates.pop_front();
               if (rsp_rate_ratio !== e.ratio) report("rate_ratio", rsp_rate_ratio, e.ratio);
               if (rsp_held !== e.held) report("held", 32'(rsp_held), 32'(e.held));
            end
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall <= stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) stall <= $urandom_range(1, 3);
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > LIMIT_CYCLES) begin
         $display("[usb_audio_rate_estimator] ERROR");
         $finish;
      end
   end

   // writes one rate register over the config bus and updates the predictor's copy of it
   task automatic csr_write(input reg_type idx, input logic [15:0] val);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= 3'(4 * idx); pwdata <= {16'h0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      bpm[idx] = 32'(val);
   endtask

   task automatic add_word(input op_type op, input logic [31:0] ts, input logic [15:0] len,
                           input logic dir, input logic upd);
      pending_words.push_back('{op, ts, len, dir, upd});
      total_words++;
   endtask

   task automatic drain();
      while (accepted != total_words || expected_rates.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // a stream of frames for both directions with random content
   task automatic add_stream(input int n, inout logic [31:0] ts, input int step_hi);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         ts += $urandom_range(0, step_hi);
         if (r < 60) add_word(OP_SAMPLE, ts, 16'($urandom_range(0, 400)), 1'($urandom),
                              $urandom_range(0, 4) != 0);
         else if (r < 80) add_word(OP_SOF, ts, 16'($urandom), 1'($urandom), 1'($urandom));
         else if (r < 86) begin
            // idle run of SOF words that may arm a hold
            repeat ($urandom_range(9, 11)) add_word(OP_SOF, ts, 16'($urandom), 0, 0);
         end else if (r < 90) add_word(OP_RESTART, ts, 16'($urandom), 1'($urandom), 1'($urandom));
         else if (r < 92) add_word(OP_NONE, $urandom, 16'($urandom), 1'($urandom), 1'($urandom));
         else add_word(OP_SAMPLE, $urandom, 16'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      logic [31:0] ts;
      predictor_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed: restart seeding, extremes, hold, bucket close, wrap
      add_word(OP_SAMPLE, 32'h0, 16'h0, 0, 0);
      add_word(OP_SAMPLE, 32'h100, 16'h0, 1, 1);
      add_word(OP_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 0, 1);
      add_word(OP_SAMPLE, 32'h0200_0000, 16'hFFFF, 0, 1);
      add_word(OP_SAMPLE, 32'h0400_0000, 16'h1234, 1, 1);
      add_word(OP_SAMPLE, 32'h0400_0010, 16'h0, 1, 0);
      add_word(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 1, 1);
      repeat (10) add_word(OP_SOF, 32'h0, 16'h0, 0, 0);
      add_word(OP_SAMPLE, 32'h0500_0000, 16'h10, 1, 1);
      add_word(OP_SOF, 32'h0, 16'h0, 0, 0);
      add_word(OP_RESTART, 32'h0, 16'h0, 0, 0);
      add_word(OP_SAMPLE, 32'h0600_0000, 16'h10, 0, 1);
      add_word(OP_SAMPLE, 32'h0600_0000, 16'h10, 0, 1);
      drain();
      csr_write(REG_OUT_BPM, 16'd1);
      csr_write(REG_IN_BPM, 16'hFFFF);
      ts = 32'hFFF0_0000;
      add_stream(200, ts, 40_000_000);
      drain();
      // long receiver hold-off while the sender keeps offering
      hold_off = 1'b1;
      add_stream(30, ts, 1_000_000);
      repeat (2000) @(posedge clock);
      hold_off = 1'b0;
      drain();
      csr_write(REG_OUT_BPM, 16'hFFFF);
      csr_write(REG_IN_BPM, 16'd1);
      add_word(OP_RESTART, ts, 0, 0, 0);
      add_stream(320, ts, 30_000_000);
      drain();
      csr_write(REG_OUT_BPM, 16'($urandom_range(1, 65535)));
      csr_write(REG_IN_BPM, 16'($urandom_range(1, 65535)));
      add_word(OP_RESTART, ts, 0, 0, 0);
      add_stream(320, ts, 100_000);
      calm = 1'b1;
      add_stream(130, ts, 60_000_000);
      drain();
      if (errors == 0) $display("[usb_audio_rate_estimator] OK");
      else $display("[usb_audio_rate_estimator] ERROR");
      $finish;
   end

endmodule
